FILE: hw/rtl/tsfd_pkg.sv
// ============================================================================
// tsfd_pkg
// Shared constants and types of the tempo-synced stereo feedback delay:
// default sizes, configuration register indexes, reset values and Q1.15
// constants.
// ============================================================================
package tsfd_pkg;

    // Default sizes handed to the top level.
    localparam int DELAY_FRAMES_DEF = 262144;
    localparam int SAMPLE_RATE_DEF  = 48000;
    localparam int SAMPLE_BITS_DEF  = 24;

    // Configuration port.
    localparam int CFG_AW = 2;
    localparam int CFG_DW = 18;

    localparam logic [CFG_AW-1:0] REG_BEATS    = 2'd0;
    localparam logic [CFG_AW-1:0] REG_FEEDBACK = 2'd1;
    localparam logic [CFG_AW-1:0] REG_MIX      = 2'd2;
    localparam logic [CFG_AW-1:0] REG_TEMPO    = 2'd3;

    // Register widths.
    localparam int BEATS_W = 4;
    localparam int GAIN_W  = 16;
    localparam int TEMPO_W = 18;

    // Register reset values.
    localparam logic [BEATS_W-1:0] BEATS_RST    = 4'd4;
    localparam logic [GAIN_W-1:0]  FEEDBACK_RST = 16'd16384;
    localparam logic [GAIN_W-1:0]  MIX_RST      = 16'd16384;
    localparam logic [TEMPO_W-1:0] TEMPO_RST    = 18'd30720;

    // Largest beats exponent honored.
    localparam int                 BEATS_LIMIT   = 8;
    localparam logic [BEATS_W-1:0] BEATS_MAX     = 4'd8;

    // Q1.15 constants.
    localparam logic [GAIN_W-1:0] Q15_ONE  = 16'd32768;
    localparam logic [GAIN_W-1:0] Q15_HALF = 16'd16384;

    // Delay lengths up to this many frames need the write-back interlock.
    localparam int HAZ_SPAN = 2;

    // Output queue.
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int FIFO_CW    = 4;
    localparam int OCC_W      = 5;

    // Status of the delay length unit.
    typedef struct packed {
        logic busy;
        logic done;
    } t_len_stat;

endpackage

FILE: hw/rtl/tempo_synced_feedback_delay_top.sv
// An accepted item passes the pipeline stages and then the output queue to the output.
// Input takes one item per cycle while the queue has room and no length update runs; with a
// delay length of 1 or 2 frames an item waits until the items ahead of it have written back.
// Reset (synchronous, active low) clears pointers, queue and registers; the length unit
// then runs with input ready low, as after each beats or tempo write.
// Frames not yet written since reset read as zero through fill tracking; no clearing pass.
// ============================================================================
// tempo_synced_feedback_delay_top
// Stereo feedback delay with a tempo-derived length. Each item reads the tap
// frame from the frame store, scales it by the feedback gain, writes back the
// saturated sum with the input and emits a dry/wet mix.
// ============================================================================
module tempo_synced_feedback_delay_top
    import tsfd_pkg::*;
#(
    parameter int DELAY_FRAMES = DELAY_FRAMES_DEF,
    parameter int SAMPLE_RATE  = SAMPLE_RATE_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Input stream; tdata: left_in, right_in (from bit 0 up), zero padded.
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,
    // Output stream; tdata: left_out, right_out (from bit 0 up), zero padded.
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     m_axis_tdata,
    // Configuration write channel.
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [CFG_AW-1:0]                      i_cfg_addr,
    input  logic [CFG_DW-1:0]                      i_cfg_data
);

    localparam int SB  = SAMPLE_BITS;
    localparam int FW  = 2 * SB;
    localparam int TDW = ((FW + 7) / 8) * 8;
    localparam int AW  = $clog2(DELAY_FRAMES);
    localparam int LW  = $clog2(DELAY_FRAMES + 1);
    localparam int PW  = SB + GAIN_W + 1;
    localparam int RW  = SB + 2;

    localparam logic [AW-1:0]   WP_LAST  = AW'(DELAY_FRAMES - 1);
    localparam logic [LW-1:0]   K_FRAMES = LW'(DELAY_FRAMES);
    localparam logic [LW:0]     K_FRAMES_X = (LW+1)'(DELAY_FRAMES);
    localparam logic signed [RW-1:0] SMAX = {{(RW-SB+1){1'b0}}, {(SB-1){1'b1}}};
    localparam logic signed [RW-1:0] SMIN = {{(RW-SB+1){1'b1}}, {(SB-1){1'b0}}};

    // Q1.15 product rounded half up, i.e. floor((p + 16384) / 32768).
    function automatic logic signed [RW-1:0] qround(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] t;
        t = p + PW'(16384);
        return RW'(t >>> 15);
    endfunction

    // Saturation to the sample range.
    function automatic logic signed [SB-1:0] sat(input logic signed [RW-1:0] v);
        logic signed [RW-1:0] t;
        t = v;
        if (v > SMAX) begin
            t = SMAX;
        end else if (v < SMIN) begin
            t = SMIN;
        end
        return t[SB-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [BEATS_W-1:0] r_beats;
    logic [GAIN_W-1:0]  r_fb;
    logic [GAIN_W-1:0]  r_mix;
    logic [TEMPO_W-1:0] r_tempo;
    logic               w_cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beats <= BEATS_RST;
            r_fb    <= FEEDBACK_RST;
            r_mix   <= MIX_RST;
            r_tempo <= TEMPO_RST;
        end else if (w_cfg_wr) begin
            case (i_cfg_addr)
                REG_BEATS:    r_beats <= i_cfg_data[BEATS_W-1:0];
                REG_FEEDBACK: r_fb    <= i_cfg_data[GAIN_W-1:0];
                REG_MIX:      r_mix   <= i_cfg_data[GAIN_W-1:0];
                REG_TEMPO:    r_tempo <= i_cfg_data[TEMPO_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Gains, clamped to one.
    logic [GAIN_W-1:0] w_fg, w_mx, w_dry, w_wet;

    always_comb begin
        w_fg  = (r_fb > Q15_ONE) ? Q15_ONE : r_fb;
        w_mx  = (r_mix > Q15_ONE) ? Q15_ONE : r_mix;
        w_dry = (w_mx > Q15_HALF) ? GAIN_W'(17'h10000 - {w_mx, 1'b0}) : Q15_ONE;
        w_wet = (w_mx < Q15_HALF) ? {w_mx[GAIN_W-2:0], 1'b0} : Q15_ONE;
    end

    // ------------------------------------------------------------------
    // Delay length: recomputed after reset and after beats or tempo writes
    // ------------------------------------------------------------------
    t_len_stat     w_len_stat;
    logic [LW-1:0] w_len;
    logic          r_len_req, n_len_req;
    logic          w_len_start;
    logic [LW-1:0] r_back;
    logic          r_short;
    logic          r_len_nz;

    assign w_len_start = r_len_req && !w_len_stat.busy;

    always_comb begin
        n_len_req = r_len_req;
        if (w_cfg_wr && (i_cfg_addr == REG_BEATS || i_cfg_addr == REG_TEMPO)) begin
            n_len_req = 1'b1;
        end else if (w_len_start) begin
            n_len_req = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_req <= 1'b1;
        end else begin
            r_len_req <= n_len_req;
        end
    end

    tsfd_len #(
        .DELAY_FRAMES (DELAY_FRAMES),
        .SAMPLE_RATE  (SAMPLE_RATE)
    ) u_len (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_len_start),
        .i_beats (r_beats),
        .i_tempo (r_tempo),
        .o_stat  (w_len_stat),
        .o_len   (w_len)
    );

    // Tap offset and interlock flag derived once per new length.
    always_ff @(posedge i_clk) begin
        if (w_len_stat.done) begin
            r_back   <= K_FRAMES - w_len;
            r_len_nz <= (w_len != '0);
            r_short  <= (w_len != '0) && (w_len <= LW'(HAZ_SPAN));
        end
    end

    // ------------------------------------------------------------------
    // Accept, tap address and fill tracking
    // ------------------------------------------------------------------
    logic [AW-1:0]  r_wp;
    logic           r_wrapped;
    logic [LW:0]    w_sum;
    logic           w_sum_ge;
    logic [LW:0]    w_rd_full;
    logic [AW-1:0]  w_rd;
    logic           w_tap_ok;
    logic           w_haz;
    logic           w_acc;
    logic [OCC_W-1:0] w_occ;

    logic           r1_valid, r2_valid, r3_valid, r4_valid;
    logic [FIFO_CW-1:0] r_fifo_cnt;
    logic [AW-1:0]  r2_wp;

    always_comb begin
        w_sum     = (LW+1)'(r_wp) + (LW+1)'(r_back);
        w_sum_ge  = (w_sum >= K_FRAMES_X);
        w_rd_full = w_sum_ge ? (w_sum - K_FRAMES_X) : w_sum;
        w_rd      = w_rd_full[AW-1:0];
        w_tap_ok  = r_wrapped || (w_sum_ge && r_len_nz);
        w_haz     = r_short && (r1_valid || r2_valid);
        w_occ     = OCC_W'(r_fifo_cnt) + OCC_W'(r1_valid) + OCC_W'(r2_valid)
                  + OCC_W'(r3_valid) + OCC_W'(r4_valid);
    end

    assign s_axis_tready = !r_len_req && !w_len_stat.busy && !w_len_stat.done
                         && !w_haz && (w_occ < OCC_W'(FIFO_DEPTH));
    assign w_acc = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_wrapped <= 1'b0;
        end else if (w_acc) begin
            if (r_wp == WP_LAST) begin
                r_wp      <= '0;
                r_wrapped <= 1'b1;
            end else begin
                r_wp <= r_wp + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Frame store
    // ------------------------------------------------------------------
    logic [FW-1:0] w_ram_rdata;
    logic [FW-1:0] w_ram_wdata;

    tsfd_ram #(
        .WIDTH (FW),
        .DEPTH (DELAY_FRAMES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (r2_valid),
        .i_waddr (r2_wp),
        .i_wdata (w_ram_wdata),
        .i_re    (w_acc),
        .i_raddr (w_rd),
        .o_rdata (w_ram_rdata)
    );

    // ------------------------------------------------------------------
    // Stage 1: tap arrives, feedback and dry products
    // ------------------------------------------------------------------
    logic                 r1_tap_ok;
    logic [AW-1:0]        r1_wp;
    logic signed [SB-1:0] r1_l, r1_r;
    logic signed [SB-1:0] w_tap_l, w_tap_r;

    always_ff @(posedge i_clk) begin
        r1_tap_ok <= w_tap_ok;
        r1_wp     <= r_wp;
        r1_l      <= s_axis_tdata[SB-1:0];
        r1_r      <= s_axis_tdata[FW-1:SB];
    end

    always_comb begin
        w_tap_l = r1_tap_ok ? w_ram_rdata[SB-1:0]  : '0;
        w_tap_r = r1_tap_ok ? w_ram_rdata[FW-1:SB] : '0;
    end

    // ------------------------------------------------------------------
    // Stage 2: round tap, write back, round dry
    // ------------------------------------------------------------------
    logic signed [SB-1:0] r2_l, r2_r;
    logic signed [PW-1:0] r2_pt_l, r2_pt_r, r2_pd_l, r2_pd_r;
    logic signed [RW-1:0] w_tl_l, w_tl_r;

    always_ff @(posedge i_clk) begin
        r2_wp   <= r1_wp;
        r2_l    <= r1_l;
        r2_r    <= r1_r;
        r2_pt_l <= w_tap_l * signed'({1'b0, w_fg});
        r2_pt_r <= w_tap_r * signed'({1'b0, w_fg});
        r2_pd_l <= r1_l * signed'({1'b0, w_dry});
        r2_pd_r <= r1_r * signed'({1'b0, w_dry});
    end

    always_comb begin
        w_tl_l      = qround(r2_pt_l);
        w_tl_r      = qround(r2_pt_r);
        w_ram_wdata = {sat(w_tl_r + RW'(r2_r)), sat(w_tl_l + RW'(r2_l))};
    end

    // ------------------------------------------------------------------
    // Stage 3: wet products
    // ------------------------------------------------------------------
    logic signed [SB-1:0] r3_tl_l, r3_tl_r, r3_dry_l, r3_dry_r;

    always_ff @(posedge i_clk) begin
        r3_tl_l  <= w_tl_l[SB-1:0];
        r3_tl_r  <= w_tl_r[SB-1:0];
        r3_dry_l <= SB'(qround(r2_pd_l));
        r3_dry_r <= SB'(qround(r2_pd_r));
    end

    // ------------------------------------------------------------------
    // Stage 4: mix and saturate into the output queue
    // ------------------------------------------------------------------
    logic signed [PW-1:0] r4_pw_l, r4_pw_r;
    logic signed [SB-1:0] r4_dry_l, r4_dry_r;
    logic [FW-1:0]        w_mix_out;

    always_ff @(posedge i_clk) begin
        r4_pw_l  <= r3_tl_l * signed'({1'b0, w_wet});
        r4_pw_r  <= r3_tl_r * signed'({1'b0, w_wet});
        r4_dry_l <= r3_dry_l;
        r4_dry_r <= r3_dry_r;
    end

    always_comb begin
        w_mix_out = {sat(qround(r4_pw_r) + RW'(r4_dry_r)),
                     sat(qround(r4_pw_l) + RW'(r4_dry_l))};
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else begin
            r1_valid <= w_acc;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    // ------------------------------------------------------------------
    // Output queue; accept only reserves room, so a push always fits
    // ------------------------------------------------------------------
    logic [FW-1:0]      r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_fifo_wp, r_fifo_rp;
    logic               w_pop;

    assign w_pop = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (r4_valid) begin
            r_fifo[r_fifo_wp] <= w_mix_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fifo_wp  <= '0;
            r_fifo_rp  <= '0;
            r_fifo_cnt <= '0;
        end else begin
            if (r4_valid) begin
                r_fifo_wp <= r_fifo_wp + 1'b1;
            end
            if (w_pop) begin
                r_fifo_rp <= r_fifo_rp + 1'b1;
            end
            r_fifo_cnt <= r_fifo_cnt + FIFO_CW'(r4_valid) - FIFO_CW'(w_pop);
        end
    end

    assign m_axis_tvalid = (r_fifo_cnt != '0);
    assign m_axis_tdata  = TDW'(r_fifo[r_fifo_rp]);

endmodule

FILE: hw/rtl/tsfd_ram.sv
// ============================================================================
// tsfd_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. A read and a write of the same entry in one cycle
// return the old contents.
// ============================================================================
module tsfd_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/tsfd_len.sv
// ============================================================================
// tsfd_len
// Delay length unit. Divides SAMPLE_RATE*960 by the tempo one quotient bit
// per cycle, shifts the quotient left by the beats exponent, then halves it
// one step per cycle until it fits the frame store.
// ============================================================================
module tsfd_len
    import tsfd_pkg::*;
#(
    parameter int DELAY_FRAMES = DELAY_FRAMES_DEF,
    parameter int SAMPLE_RATE  = SAMPLE_RATE_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [BEATS_W-1:0]               i_beats,
    input  logic [TEMPO_W-1:0]               i_tempo,
    output t_len_stat                        o_stat,
    output logic [$clog2(DELAY_FRAMES+1)-1:0] o_len
);

    // Sixteenth-beat length in frames is SAMPLE_RATE*60*256/16 over tempo.
    localparam int DIVIDEND = SAMPLE_RATE * 960;
    localparam int QW       = $clog2(DIVIDEND + 1);
    localparam int CW       = $clog2(QW);
    localparam int SW       = QW + BEATS_LIMIT;
    localparam int LW       = $clog2(DELAY_FRAMES + 1);

    localparam logic [QW-1:0] K_DIVIDEND = QW'(DIVIDEND);
    localparam logic [SW-1:0] K_FRAMES   = SW'(DELAY_FRAMES);

    localparam logic [1:0] L_IDLE = 2'd0;
    localparam logic [1:0] L_DIV  = 2'd1;
    localparam logic [1:0] L_NORM = 2'd2;

    logic [1:0]         r_state, n_state;
    logic               r_done, n_done;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [TEMPO_W-1:0] r_div, n_div;
    logic [TEMPO_W-1:0] r_rem, n_rem;
    logic [QW-1:0]      r_quo, n_quo;
    logic [BEATS_W-1:0] r_b, n_b;
    logic [SW-1:0]      r_len_sh, n_len_sh;
    logic [LW-1:0]      r_len, n_len;

    logic [TEMPO_W:0]   w_rem_sh;
    logic               w_ge;
    logic [QW-1:0]      w_quo;

    // One restoring division step.
    always_comb begin
        w_rem_sh = {r_rem, K_DIVIDEND[r_cnt]};
        w_ge     = (w_rem_sh >= {1'b0, r_div});
        w_quo    = {r_quo[QW-2:0], w_ge};
    end

    // Sequencer.
    always_comb begin
        n_state  = r_state;
        n_done   = 1'b0;
        n_cnt    = r_cnt;
        n_div    = r_div;
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_b      = r_b;
        n_len_sh = r_len_sh;
        n_len    = r_len;
        case (r_state)
            L_IDLE: begin
                if (i_start) begin
                    n_div   = (i_tempo == '0) ? TEMPO_W'(1) : i_tempo;
                    n_b     = (i_beats > BEATS_MAX) ? BEATS_MAX : i_beats;
                    n_rem   = '0;
                    n_quo   = '0;
                    n_cnt   = CW'(QW - 1);
                    n_state = L_DIV;
                end
            end
            L_DIV: begin
                n_rem = w_ge ? TEMPO_W'(w_rem_sh - {1'b0, r_div})
                             : w_rem_sh[TEMPO_W-1:0];
                n_quo = w_quo;
                if (r_cnt == '0) begin
                    n_len_sh = SW'(w_quo) << r_b;
                    n_state  = L_NORM;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            L_NORM: begin
                if (r_len_sh > K_FRAMES) begin
                    n_len_sh = r_len_sh >> 1;
                end else begin
                    n_len   = r_len_sh[LW-1:0];
                    n_done  = 1'b1;
                    n_state = L_IDLE;
                end
            end
            default: begin
                n_state = L_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_cnt    <= n_cnt;
        r_div    <= n_div;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_b      <= n_b;
        r_len_sh <= n_len_sh;
        r_len    <= n_len;
    end

    assign o_stat.busy = (r_state != L_IDLE);
    assign o_stat.done = r_done;
    assign o_len       = r_len;

endmodule

FILE: hw/rtl/tsfd_checker.sv
// ============================================================================
// tsfd_checker
// Port-level checks of the tempo-synced feedback delay, bound to the top
// level.
// ============================================================================
module tsfd_checker
    import tsfd_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
    input logic                               i_cfg_valid,
    input logic                               o_cfg_ready,
    input logic [CFG_AW-1:0]                  i_cfg_addr
);

    // A stalled result item holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output item changed");

    // Reset empties the output and blocks input while the length is derived.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && !s_axis_tready)
        else $error("reset did not clear the stream sides");

    // A new length blocks input until it has been derived.
    a_len_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready
        && (i_cfg_addr == REG_BEATS || i_cfg_addr == REG_TEMPO)
        |=> !s_axis_tready)
        else $error("input accepted during a length update");

    // An output appearing from empty stems from an earlier accepted item that passed the pipeline.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 5))
        else $error("output item without a matching input item");

endmodule

bind tempo_synced_feedback_delay_top tsfd_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_tsfd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .i_cfg_valid   (i_cfg_valid),
    .o_cfg_ready   (o_cfg_ready),
    .i_cfg_addr    (i_cfg_addr)
);
